// File: rtl/core/iimu_pkg.sv
// ----------------------------------------------------------------------------
// iimu_pkg
// Shared types, codes, limits and lookup tables of the integer math unit.
// ----------------------------------------------------------------------------
package iimu_pkg;

    localparam int unsigned OPERAND_WIDTH_DEF = 16;
    localparam int unsigned LIMIT_W           = 15;
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 15'd64;

    // power unit: base below 2^31, exponent 0..31, one exponent bit per stage
    localparam int unsigned POW_W      = 31;
    localparam int unsigned POW_STAGES = 5;

    localparam logic signed [31:0] R_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] R_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        MD_ADD  = 3'd0,
        MD_SUB  = 3'd1,
        MD_MUL  = 3'd2,
        MD_DIV  = 3'd3,
        MD_POW  = 3'd4,
        MD_FACT = 3'd5,
        MD_FIB  = 3'd6,
        MD_SQRT = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NEG     = 3'd1,
        ST_LIMIT   = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_OVF     = 3'd4
    } t_status;

    localparam int unsigned FACT_MAX = 12;
    localparam int unsigned FIB_MAX  = 46;

    localparam logic [31:0] FACT_TAB [0:12] = '{
        32'd1, 32'd1, 32'd2, 32'd6, 32'd24, 32'd120, 32'd720, 32'd5040,
        32'd40320, 32'd362880, 32'd3628800, 32'd39916800, 32'd479001600
    };

    localparam logic [31:0] FIB_TAB [0:46] = '{
        32'd0, 32'd1, 32'd1, 32'd2, 32'd3, 32'd5, 32'd8, 32'd13,
        32'd21, 32'd34, 32'd55, 32'd89, 32'd144, 32'd233, 32'd377, 32'd610,
        32'd987, 32'd1597, 32'd2584, 32'd4181, 32'd6765, 32'd10946, 32'd17711,
        32'd28657, 32'd46368, 32'd75025, 32'd121393, 32'd196418, 32'd317811,
        32'd514229, 32'd832040, 32'd1346269, 32'd2178309, 32'd3524578,
        32'd5702887, 32'd9227465, 32'd14930352, 32'd24157817, 32'd39088169,
        32'd63245986, 32'd102334155, 32'd165580141, 32'd267914296,
        32'd433494437, 32'd701408733, 32'd1134903170, 32'd1836311903
    };

endpackage

// File: rtl/core/iimu_delay.sv
// ----------------------------------------------------------------------------
// iimu_delay
// Stallable shift line that aligns a bundle with the longest unit.
// ----------------------------------------------------------------------------
module iimu_delay #(
    parameter int unsigned DW    = 8,
    parameter int unsigned DEPTH = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_d,
    output logic [DW-1:0] o_q
);

    logic [DW-1:0] r_sh [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_q = r_sh[DEPTH-1];

endmodule

// File: rtl/core/iimu_div.sv
// ----------------------------------------------------------------------------
// iimu_div
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module iimu_div #(
    parameter int unsigned W = 16
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic [W-1:0] o_quo
);

    logic [W-1:0] r_rem [W];
    logic [W-1:0] r_nq  [W];
    logic [W-1:0] r_den [W];
    logic [W-1:0] n_rem [W];
    logic [W-1:0] n_nq  [W];
    logic [W-1:0] x_rem [W+1];
    logic [W-1:0] x_nq  [W+1];
    logic [W-1:0] x_den [W+1];

    always_comb begin
        x_rem[0] = '0;
        x_nq[0]  = i_num;
        x_den[0] = i_den;
        for (int k = 0; k < W; k++) begin
            x_rem[k+1] = r_rem[k];
            x_nq[k+1]  = r_nq[k];
            x_den[k+1] = r_den[k];
        end
    end

    always_comb begin
        logic [W:0] t;
        logic       ge;
        for (int k = 0; k < W; k++) begin
            t  = {x_rem[k], x_nq[k][W-1]};
            ge = (t >= {1'b0, x_den[k]});
            n_rem[k] = ge ? W'(t - {1'b0, x_den[k]}) : t[W-1:0];
            n_nq[k]  = {x_nq[k][W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_den[k] <= x_den[k];
            end
        end
    end

    assign o_quo = r_nq[W-1];

endmodule

// File: rtl/core/iimu_sqrt.sv
// ----------------------------------------------------------------------------
// iimu_sqrt
// Pipelined digit-by-digit square root, two radicand bits per stage.
// Returns the floor root and the remainder n - root^2.
// ----------------------------------------------------------------------------
module iimu_sqrt #(
    parameter int unsigned W = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [W-1:0]           i_rad,
    output logic [(W+1)/2-1:0]     o_root,
    output logic [(W+1)/2+2:0]     o_rem
);

    localparam int unsigned N2 = (W + 1) / 2;
    localparam int unsigned IW = 2 * N2;
    localparam int unsigned RW = N2 + 3;

    logic [IW-1:0] r_x    [N2];
    logic [N2-1:0] r_root [N2];
    logic [RW-1:0] r_rem  [N2];
    logic [IW-1:0] n_x    [N2];
    logic [N2-1:0] n_root [N2];
    logic [RW-1:0] n_rem  [N2];
    logic [IW-1:0] x_x    [N2+1];
    logic [N2-1:0] x_root [N2+1];
    logic [RW-1:0] x_rem  [N2+1];

    always_comb begin
        x_x[0]    = IW'(i_rad);
        x_root[0] = '0;
        x_rem[0]  = '0;
        for (int k = 0; k < N2; k++) begin
            x_x[k+1]    = r_x[k];
            x_root[k+1] = r_root[k];
            x_rem[k+1]  = r_rem[k];
        end
    end

    always_comb begin
        logic [RW-1:0] t;
        logic [RW-1:0] trial;
        logic          ge;
        for (int k = 0; k < N2; k++) begin
            t     = {x_rem[k][RW-3:0], x_x[k][IW-1 -: 2]};
            trial = RW'({x_root[k], 2'b01});
            ge    = (t >= trial);
            n_rem[k]  = ge ? (t - trial) : t;
            n_root[k] = {x_root[k][N2-2:0], ge};
            n_x[k]    = {x_x[k][IW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N2; k++) begin
                r_x[k]    <= n_x[k];
                r_root[k] <= n_root[k];
                r_rem[k]  <= n_rem[k];
            end
        end
    end

    assign o_root = r_root[N2-1];
    assign o_rem  = r_rem[N2-1];

endmodule

// File: rtl/core/iimu_pow.sv
// ----------------------------------------------------------------------------
// iimu_pow
// Pipelined square-and-multiply power, one exponent bit per stage, with
// sticky overflow flags on the accumulator and the squared base.
// ----------------------------------------------------------------------------
module iimu_pow (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [iimu_pkg::POW_W-1:0]      i_base,
    input  logic [iimu_pkg::POW_STAGES-1:0] i_exp,
    output logic [iimu_pkg::POW_W-1:0]      o_res,
    output logic                            o_ovf
);

    import iimu_pkg::*;

    localparam int unsigned S  = POW_STAGES;
    localparam int unsigned PW = 2 * POW_W;

    logic [POW_W-1:0] r_acc  [S];
    logic             r_aovf [S];
    logic [POW_W-1:0] r_base [S];
    logic             r_bovf [S];
    logic [S-1:0]     r_exp  [S];
    logic [POW_W-1:0] n_acc  [S];
    logic             n_aovf [S];
    logic [POW_W-1:0] n_base [S];
    logic             n_bovf [S];
    logic [POW_W-1:0] x_acc  [S+1];
    logic             x_aovf [S+1];
    logic [POW_W-1:0] x_base [S+1];
    logic             x_bovf [S+1];
    logic [S-1:0]     x_exp  [S+1];

    always_comb begin
        x_acc[0]  = POW_W'(1);
        x_aovf[0] = 1'b0;
        x_base[0] = i_base;
        x_bovf[0] = 1'b0;
        x_exp[0]  = i_exp;
        for (int k = 0; k < S; k++) begin
            x_acc[k+1]  = r_acc[k];
            x_aovf[k+1] = r_aovf[k];
            x_base[k+1] = r_base[k];
            x_bovf[k+1] = r_bovf[k];
            x_exp[k+1]  = r_exp[k];
        end
    end

    always_comb begin
        logic [PW-1:0] pa;
        logic [PW-1:0] pb;
        for (int k = 0; k < S; k++) begin
            pa = PW'(x_acc[k]) * PW'(x_base[k]);
            pb = PW'(x_base[k]) * PW'(x_base[k]);
            n_base[k] = pb[POW_W-1:0];
            n_bovf[k] = x_bovf[k] | (|pb[PW-1:POW_W]);
            if (x_exp[k][k]) begin
                n_acc[k]  = pa[POW_W-1:0];
                n_aovf[k] = x_aovf[k] | x_bovf[k] | (|pa[PW-1:POW_W]);
            end else begin
                n_acc[k]  = x_acc[k];
                n_aovf[k] = x_aovf[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < S; k++) begin
                r_acc[k]  <= n_acc[k];
                r_aovf[k] <= n_aovf[k];
                r_base[k] <= n_base[k];
                r_bovf[k] <= n_bovf[k];
                r_exp[k]  <= x_exp[k];
            end
        end
    end

    assign o_res = r_acc[S-1];
    assign o_ovf = r_aovf[S-1];

endmodule

// File: rtl/core/iterative_integer_math_unit.sv
// ----------------------------------------------------------------------------
// iterative_integer_math_unit
// Pipelined integer ALU: add, sub, multiply, divide, power, factorial,
// Fibonacci and rounded square root with status codes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = mode, tdata = operand_a (low W bits) and
//   operand_b (next W bits), zero padded to whole bytes.
//   Master stream: tdata = 32-bit signed result, tuser = status.
//   Every word in gives exactly one word out, in order.
//   The divider resolves one quotient bit per stage; the square root and
//   power units are padded to the same depth. Throughput is one word per
//   cycle while the receiver is not holding the output word.
//   The whole pipeline advances together; when the output word is held by
//   the receiver, s_axis_tready drops and every stage keeps its contents.
//   Reset empties the pipeline and sets the power base limit to 64.
//   The limit register is written through i_cfg_wen / i_cfg_wdata; the user
//   must write it only while the unit is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module iterative_integer_math_unit #(
    parameter int unsigned OPERAND_WIDTH = iimu_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // operand_a, operand_b
    input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // mode
    input  logic [2:0]                              s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // result
    output logic [31:0]                             m_axis_tdata,
    // status
    output logic [2:0]                              m_axis_tuser,
    input  logic                                    i_cfg_wen,
    input  logic [iimu_pkg::LIMIT_W-1:0]            i_cfg_wdata
);

    import iimu_pkg::*;

    localparam int unsigned W   = OPERAND_WIDTH;
    localparam int unsigned XW  = 2 * W + 2;
    localparam int unsigned N2  = (W + 1) / 2;
    localparam int unsigned RW  = N2 + 3;
    localparam int unsigned PL  = W + 3;
    localparam int unsigned CW  = (W > LIMIT_W) ? W : LIMIT_W;
    localparam int unsigned SDW = 9 + XW + 2 * W;

    logic [LIMIT_W-1:0] r_limit;
    logic [PL-1:0]      r_vld;
    logic               w_en;

    t_mode              r1_mode;
    logic signed [W-1:0] r1_a;
    logic signed [W-1:0] r1_b;

    logic [W-1:0]        w_ma, w_mb;
    logic                w_neg, w_povf, w_usep;
    t_status             w_pre;
    logic signed [XW-1:0] w_simple;
    logic [2*W-1:0]      w_prod;
    logic [3:0]          w_fi;
    logic [5:0]          w_bi;

    logic [W-1:0]        r2_ma, r2_mb;
    logic [POW_W-1:0]    r2_pbase;
    logic [POW_STAGES-1:0] r2_pexp;
    logic [SDW-1:0]      r2_side;

    logic [W-1:0]        w_quo;
    logic [N2-1:0]       w_sroot_u;
    logic [RW-1:0]       w_srem_u;
    logic [N2-1:0]       w_sroot;
    logic [RW-1:0]       w_srem;
    logic [POW_W-1:0]    w_pres_u, w_pres;
    logic                w_povf_u, w_pow_ovf;
    logic [SDW-1:0]      w_sd;

    t_mode               d_mode;
    t_status             d_pre;
    logic                d_povf, d_usep, d_neg;
    logic signed [XW-1:0] d_simple;
    logic [2*W-1:0]      d_prod;

    logic signed [XW-1:0] w_val;
    logic [XW-1:0]       w_mag;
    logic                w_uovf;
    t_status             w_st;

    logic [31:0]         r_out_data;
    logic [2:0]          r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (i_cfg_wen) begin
            r_limit <= i_cfg_wdata;
        end
    end

    assign w_en          = !r_vld[PL-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PL-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_mode <= t_mode'(s_axis_tuser);
            r1_a    <= s_axis_tdata[W-1:0];
            r1_b    <= s_axis_tdata[2*W-1:W];
        end
    end

    // decode, sign handling, multiply, table lookups
    always_comb begin
        w_ma   = r1_a[W-1] ? W'(-r1_a) : r1_a;
        w_mb   = r1_b[W-1] ? W'(-r1_b) : r1_b;
        w_neg  = r1_a[W-1] ^ r1_b[W-1];
        w_prod = (2*W)'(w_ma) * (2*W)'(w_mb);
        w_fi   = ($unsigned(r1_a) > FACT_MAX) ? 4'(FACT_MAX) : r1_a[3:0];
        w_bi   = ($unsigned(r1_a) > FIB_MAX) ? 6'(FIB_MAX) : r1_a[5:0];
        w_pre    = ST_OK;
        w_povf   = 1'b0;
        w_usep   = 1'b0;
        w_simple = '0;
        unique case (r1_mode)
            MD_ADD: w_simple = XW'(r1_a) + XW'(r1_b);
            MD_SUB: w_simple = XW'(r1_a) - XW'(r1_b);
            MD_MUL: w_simple = '0;
            MD_DIV: begin
                if (w_mb == '0) w_pre = ST_DIVZERO;
            end
            MD_POW: begin
                if (r1_a < 0 || r1_b < 0) begin
                    w_pre = ST_NEG;
                end else if (CW'($unsigned(r1_a)) > CW'(r_limit)) begin
                    w_pre = ST_LIMIT;
                end else if (r1_b == 0) begin
                    w_simple = XW'(1);
                end else if (r1_a == 0) begin
                    w_simple = '0;
                end else if (r1_a == 1) begin
                    w_simple = XW'(1);
                end else begin
                    w_usep = 1'b1;
                    w_povf = ($unsigned(r1_b) > 31);
                end
            end
            MD_FACT: begin
                if (r1_a < 0) begin
                    w_pre = ST_NEG;
                end else begin
                    w_simple = XW'(FACT_TAB[w_fi]);
                    w_povf   = ($unsigned(r1_a) > FACT_MAX);
                end
            end
            MD_FIB: begin
                if (r1_a < 0) begin
                    w_pre = ST_NEG;
                end else begin
                    w_simple = XW'(FIB_TAB[w_bi]);
                    w_povf   = ($unsigned(r1_a) > FIB_MAX);
                end
            end
            MD_SQRT: begin
                if (r1_a < 0) w_pre = ST_NEG;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ma    <= w_ma;
            r2_mb    <= w_mb;
            r2_pbase <= POW_W'($unsigned(r1_a));
            r2_pexp  <= r1_b[POW_STAGES-1:0];
            r2_side  <= {w_prod, w_simple, w_neg, w_usep, w_povf, w_pre, r1_mode};
        end
    end

    iimu_div #(.W(W)) u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r2_ma),
        .i_den (r2_mb),
        .o_quo (w_quo)
    );

    iimu_sqrt #(.W(W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r2_ma),
        .o_root (w_sroot_u),
        .o_rem  (w_srem_u)
    );

    iimu_delay #(.DW(N2 + RW), .DEPTH(W - N2)) u_sqrt_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_sroot_u, w_srem_u}),
        .o_q   ({w_sroot, w_srem})
    );

    iimu_pow u_pow (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_base (r2_pbase),
        .i_exp  (r2_pexp),
        .o_res  (w_pres_u),
        .o_ovf  (w_povf_u)
    );

    iimu_delay #(.DW(POW_W + 1), .DEPTH(W - POW_STAGES)) u_pow_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_povf_u, w_pres_u}),
        .o_q   ({w_pow_ovf, w_pres})
    );

    iimu_delay #(.DW(SDW), .DEPTH(W)) u_side_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r2_side),
        .o_q   (w_sd)
    );

    assign d_mode   = t_mode'(w_sd[2:0]);
    assign d_pre    = t_status'(w_sd[5:3]);
    assign d_povf   = w_sd[6];
    assign d_usep   = w_sd[7];
    assign d_neg    = w_sd[8];
    assign d_simple = $signed(w_sd[9 +: XW]);
    assign d_prod   = w_sd[9+XW +: 2*W];

    // result select, range check, status
    always_comb begin
        w_mag  = '0;
        w_uovf = 1'b0;
        unique case (d_mode)
            MD_MUL: begin
                w_mag = XW'(d_prod);
                w_val = d_neg ? -$signed(w_mag) : $signed(w_mag);
            end
            MD_DIV: begin
                w_mag = XW'(w_quo);
                w_val = d_neg ? -$signed(w_mag) : $signed(w_mag);
            end
            MD_POW: begin
                w_mag  = XW'(w_pres);
                w_val  = d_usep ? $signed(w_mag) : d_simple;
                w_uovf = d_usep & w_pow_ovf;
            end
            MD_SQRT: begin
                w_mag = XW'(w_sroot) + XW'(w_srem > RW'(w_sroot));
                w_val = $signed(w_mag);
            end
            MD_ADD, MD_SUB, MD_FACT, MD_FIB: w_val = d_simple;
        endcase
        if (d_pre != ST_OK) begin
            w_st = d_pre;
        end else if (d_povf || w_uovf || w_val > R_MAX || w_val < R_MIN) begin
            w_st = ST_OVF;
        end else begin
            w_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= (w_st == ST_OK) ? w_val[31:0] : 32'd0;
            r_out_st   <= w_st;
        end
    end

    assign m_axis_tvalid = r_vld[PL-1];
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_st;

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during stall");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == 32'd0)
        else $error("nonzero result with error status");

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the iterative integer math unit. Words are driven
// on the slave stream with random gaps, and the receiver stalls at random,
// outside the full-rate phase. A local predictor works out the result and
// status of each accepted word. The checker compares every output word in
// order. The power base limit is swept through its extremes between phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iimu_pkg::*;

    localparam int W          = OPERAND_WIDTH_DEF;
    localparam int LATENCY    = W + 3;
    localparam int WDOG_LIMIT = 4000;

    typedef struct packed {
        logic signed [31:0] result;
        t_status            status;
    } t_outcome;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;
    logic [2:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;
    logic [2:0]        m_axis_tuser;
    logic              i_cfg_wen = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wdata = '0;

    t_outcome    pending_q[$];
    int          n_errors = 0;
    int          idle_cycles = 0;
    bit          idling_on = 1'b1;
    int          rx_stall = 0;
    logic [14:0] base_limit = LIMIT_RST;

    iterative_integer_math_unit #(.OPERAND_WIDTH(W)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_outcome compute_outcome(t_mode md, logic signed [W-1:0] opa,
                                                 logic signed [W-1:0] opb);
        longint a, b, r, ma, mb, x, y, t, s;
        t_status st;
        t_outcome o;
        a  = opa;
        b  = opb;
        r  = 0;
        st = ST_OK;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        case (md)
            MD_ADD: r = a + b;
            MD_SUB: r = a - b;
            MD_MUL: begin
                r = ma * mb;
                if ((a < 0) != (b < 0)) r = -r;
            end
            MD_DIV: begin
                if (mb == 0) st = ST_DIVZERO;
                else r = ma / mb;
                if ((a < 0) != (b < 0)) r = -r;
            end
            MD_POW: begin
                if (a < 0 || b < 0) st = ST_NEG;
                else if (a > base_limit) st = ST_LIMIT;
                else begin
                    r = 1;
                    if (b > 0 && a == 0) r = 0;
                    else if (a > 1) begin
                        for (longint n = b; n > 0; n--) begin
                            r = r * a;
                            if (r > 64'sd2147483647) break;
                        end
                    end
                end
            end
            MD_FACT: begin
                if (a < 0) st = ST_NEG;
                else begin
                    r = 1;
                    for (longint k = 2; k <= a; k++) begin
                        r = r * k;
                        if (r > 64'sd2147483647) break;
                    end
                end
            end
            MD_FIB: begin
                if (a < 0) st = ST_NEG;
                else begin
                    x = 0;
                    y = 1;
                    for (longint i = 0; i < a; i++) begin
                        t = x + y;
                        x = y;
                        y = t;
                        if (x > 64'sd2147483647) break;
                    end
                    r = x;
                end
            end
            default: begin
                if (a < 0) st = ST_NEG;
                else begin
                    s = 0;
                    while ((s + 1) * (s + 1) <= a) s++;
                    if (a - s * s > s) s++;
                    r = s;
                end
            end
        endcase
        if (st == ST_OK && (r > 64'sd2147483647 || r < -64'sd2147483648)) st = ST_OVF;
        if (st != ST_OK) r = 0;
        o.result = r[31:0];
        o.status = st;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what,
                 $signed(got), $signed(want), $realtime);
        n_errors++;
    endtask

    // receiver with random stall bursts
    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rx_stall <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_outcome exp_o;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, 32'd0);
            end else begin
                exp_o = pending_q.pop_front();
                if (m_axis_tdata !== exp_o.result)
                    report_mismatch("result", m_axis_tdata, exp_o.result);
                if (m_axis_tuser !== exp_o.status)
                    report_mismatch("status", {29'd0, m_axis_tuser}, {29'd0, exp_o.status});
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_word(t_mode md, logic [W-1:0] opa, logic [W-1:0] opb);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= md;
        s_axis_tdata  <= {opb, opa};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_q.push_back(compute_outcome(md, opa, opb));
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [14:0] value);
        stop_sending();
        wait_drained();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        base_limit  = value;
    endtask

    task automatic send_random(int count, int small_pct);
        t_mode md;
        logic [W-1:0] opa, opb;
        for (int i = 0; i < count; i++) begin
            md  = t_mode'($urandom_range(0, 7));
            opa = W'($urandom);
            opb = W'($urandom);
            if ($urandom_range(0, 99) < small_pct) begin
                opa = W'($signed($urandom_range(0, 70)) - 3);
                if ($urandom_range(0, 1)) opb = W'($signed($urandom_range(0, 40)) - 2);
            end
            send_word(md, opa, opb);
        end
    endtask

    task automatic test_directed();
        send_word(MD_ADD, 16'h7FFF, 16'h7FFF);
        send_word(MD_ADD, 16'h8000, 16'h8000);
        send_word(MD_SUB, 16'h8000, 16'h7FFF);
        send_word(MD_SUB, 16'h7FFF, 16'h8000);
        send_word(MD_MUL, 16'h8000, 16'h8000);
        send_word(MD_MUL, -16'sd1, 16'd5);
        send_word(MD_DIV, 16'd7, -16'sd2);
        send_word(MD_DIV, 16'h8000, -16'sd1);
        send_word(MD_DIV, 16'd9, 16'd0);
        send_word(MD_POW, 16'd0, 16'd0);
        send_word(MD_POW, 16'd2, 16'd30);
        send_word(MD_POW, 16'd2, 16'd31);
        send_word(MD_POW, 16'd1, 16'h7FFF);
        send_word(MD_POW, 16'd3, -16'sd1);
        send_word(MD_POW, 16'd65, 16'd2);
        send_word(MD_FACT, 16'd0, 16'd0);
        send_word(MD_FACT, 16'd12, 16'd0);
        send_word(MD_FACT, 16'd13, 16'd0);
        send_word(MD_FACT, -16'sd1, 16'd0);
        send_word(MD_FIB, 16'd46, 16'd0);
        send_word(MD_FIB, 16'd47, 16'd0);
        send_word(MD_FIB, -16'sd5, 16'd0);
        send_word(MD_SQRT, 16'd2, 16'd0);
        send_word(MD_SQRT, 16'd3, 16'd0);
        send_word(MD_SQRT, 16'h7FFF, 16'd0);
        send_word(MD_SQRT, 16'h8000, 16'd0);
    endtask

    task automatic test_limit_extremes();
        write_limit(15'd0);
        send_word(MD_POW, 16'd0, 16'd5);
        send_word(MD_POW, 16'd1, 16'd5);
        send_random(40, 70);
        write_limit(15'h7FFF);
        send_word(MD_POW, 16'h7FFF, 16'd2);
        send_word(MD_POW, 16'h7FFF, 16'd3);
        send_random(60, 30);
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < 4; p++) begin
            write_limit(15'($urandom_range(0, 15'h7FFF) >> $urandom_range(0, 14)));
            send_random(120, 60);
        end
    endtask

    task automatic test_drained_sender();
        send_random(30, 50);
        stop_sending();
        while (pending_q.size() != 0) @(posedge i_clk);
        send_random(30, 50);
    endtask

    task automatic test_full_rate();
        write_limit(LIMIT_RST);
        idling_on = 1'b0;
        send_random(200, 50);
        stop_sending();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_limit_extremes();
        test_random_mix();
        test_drained_sender();
        test_full_rate();
        wait_drained();
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
